// File: hw/rtl/gmac_pkg.sv
// ----------------------------------------------------------------------------
// gmac_pkg
// Types, register codes and the control store for the matrix multiply-
// accumulate block.
// ----------------------------------------------------------------------------
package gmac_pkg;

  localparam int ELEM_W    = 32;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int PC_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 3'd4;

  typedef enum logic [1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_LOAD_C = 2'd2,
    MODE_RUN    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] in_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [ELEM_W-1:0] alpha;
    logic [ELEM_W-1:0] beta;
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [DIM_W-1:0]  inner;
  } cfg_t;

  typedef enum logic [2:0] {
    COND_NONE         = 3'd0,
    COND_ALWAYS       = 3'd1,
    COND_IDLE_HOLD    = 3'd2,
    COND_SKIP_INNER   = 3'd3,
    COND_MORE_INNER   = 3'd4,
    COND_OUT_BUSY     = 3'd5,
    COND_MORE_ENTRIES = 3'd6
  } cond_t;

  typedef enum logic [1:0] {
    MUL_NONE    = 2'd0,
    MUL_BETA_C  = 2'd1,
    MUL_ALPHA_B = 2'd2,
    MUL_P_A     = 2'd3
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_INIT = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    L_HOLD  = 2'd0,
    L_CLEAR = 2'd1,
    L_INC   = 2'd2
  } l_op_t;

  typedef struct packed {
    logic            accept;
    cond_t           cond;
    logic [PC_W-1:0] target;
    mul_sel_t        mul;
    acc_op_t         acc;
    l_op_t           lop;
    logic            emit;
  } ctrl_t;

  typedef struct packed {
    logic run_go;
    logic skip_inner;
    logic more_inner;
    logic out_busy;
    logic more_entries;
  } stat_t;

  localparam logic [PC_W-1:0] P_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] P_CRD    = 4'd1;
  localparam logic [PC_W-1:0] P_CMUL   = 4'd2;
  localparam logic [PC_W-1:0] P_CINIT  = 4'd3;
  localparam logic [PC_W-1:0] P_ABRD   = 4'd4;
  localparam logic [PC_W-1:0] P_MUL1   = 4'd5;
  localparam logic [PC_W-1:0] P_MUL2   = 4'd6;
  localparam logic [PC_W-1:0] P_ACC    = 4'd7;
  localparam logic [PC_W-1:0] P_EMIT   = 4'd8;
  localparam logic [PC_W-1:0] P_NEXT   = 4'd9;
  localparam logic [PC_W-1:0] P_FINISH = 4'd10;

  // control store: one word per step, jump taken when cond holds
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w.accept = 1'b0;
    w.cond   = COND_NONE;
    w.target = P_IDLE;
    w.mul    = MUL_NONE;
    w.acc    = ACC_HOLD;
    w.lop    = L_HOLD;
    w.emit   = 1'b0;
    case (pc)
      P_IDLE: begin
        w.accept = 1'b1;
        w.cond   = COND_IDLE_HOLD;
        w.target = P_IDLE;
      end
      P_CRD: begin
        w.lop = L_CLEAR;
      end
      P_CMUL: begin
        w.mul = MUL_BETA_C;
      end
      P_CINIT: begin
        w.acc    = ACC_INIT;
        w.cond   = COND_SKIP_INNER;
        w.target = P_EMIT;
      end
      P_ABRD: begin
        w.cond = COND_NONE;
      end
      P_MUL1: begin
        w.mul = MUL_ALPHA_B;
      end
      P_MUL2: begin
        w.mul = MUL_P_A;
      end
      P_ACC: begin
        w.acc    = ACC_ADD;
        w.lop    = L_INC;
        w.cond   = COND_MORE_INNER;
        w.target = P_ABRD;
      end
      P_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = P_EMIT;
      end
      P_NEXT: begin
        w.cond   = COND_MORE_ENTRIES;
        w.target = P_CRD;
      end
      P_FINISH: begin
        w.cond   = COND_ALWAYS;
        w.target = P_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = P_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/gmac_ram.sv
// ----------------------------------------------------------------------------
// gmac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gmac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/gmac_useq.sv
// ----------------------------------------------------------------------------
// gmac_useq
// Microcode sequencer: step counter, control store and jump conditions.
// ----------------------------------------------------------------------------
module gmac_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  gmac_pkg::stat_t stat,
  output gmac_pkg::ctrl_t ctrl
);

  logic [gmac_pkg::PC_W-1:0] pc_r;
  logic [gmac_pkg::PC_W-1:0] pc_nxt;
  logic                      take;

  assign ctrl = gmac_pkg::ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      gmac_pkg::COND_NONE:         take = 1'b0;
      gmac_pkg::COND_ALWAYS:       take = 1'b1;
      gmac_pkg::COND_IDLE_HOLD:    take = !stat.run_go;
      gmac_pkg::COND_SKIP_INNER:   take = stat.skip_inner;
      gmac_pkg::COND_MORE_INNER:   take = stat.more_inner;
      gmac_pkg::COND_OUT_BUSY:     take = stat.out_busy;
      gmac_pkg::COND_MORE_ENTRIES: take = stat.more_entries;
      default:                     take = 1'b0;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= gmac_pkg::P_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    stat.run_go |=> pc_r == gmac_pkg::P_CRD)
    else $error("run start did not enter the entry loop");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= gmac_pkg::P_FINISH)
    else $error("step counter outside the program");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == gmac_pkg::P_EMIT) && stat.out_busy |=> pc_r == gmac_pkg::P_EMIT)
    else $error("emit step left while output register busy");

endmodule

// File: hw/rtl/gmac_dpath.sv
// ----------------------------------------------------------------------------
// gmac_dpath
// Datapath: A/B/C stores, index counters, shared multiplier, accumulator
// and result register.
// ----------------------------------------------------------------------------
module gmac_dpath #(
  parameter int MAX_DIM = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gmac_pkg::cfg_t     cfg,
  input  gmac_pkg::ctrl_t    ctrl,
  output gmac_pkg::stat_t    stat,
  input  logic               in_valid,
  output logic               in_stall,
  input  gmac_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output gmac_pkg::out_item_t out_item
);

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW     = gmac_pkg::ELEM_W;
  localparam int DW     = gmac_pkg::DIM_W;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

  logic [DW-1:0]     rows_c, cols_c, inner_c;
  logic [DW-1:0]     rows_m1, cols_m1, inner_m1;
  logic              in_acc, ld_ok, is_last, emit_go, out_busy, empty;
  logic [ADDR_W-1:0] ld_addr, a_addr, b_addr, c_addr, c_waddr;
  logic [EW-1:0]     c_wdata, a_rd, b_rd, c_rd;
  logic [EW-1:0]     mul_x, mul_y;

  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt, l_r, l_nxt;
  logic              fin_r, fin_nxt;
  logic [EW-1:0]     p_r, p_nxt, acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  gmac_pkg::out_item_t out_item_r, out_item_nxt;

  assign rows_c  = (cfg.rows  > DW'(MAX_DIM)) ? DW'(MAX_DIM) : cfg.rows;
  assign cols_c  = (cfg.cols  > DW'(MAX_DIM)) ? DW'(MAX_DIM) : cfg.cols;
  assign inner_c = (cfg.inner > DW'(MAX_DIM)) ? DW'(MAX_DIM) : cfg.inner;
  assign rows_m1  = rows_c - 1'b1;
  assign cols_m1  = cols_c - 1'b1;
  assign inner_m1 = inner_c - 1'b1;
  assign empty    = (rows_c == '0) || (cols_c == '0);

  assign in_stall = !ctrl.accept;
  assign in_acc   = in_valid && !in_stall;
  assign ld_ok    = (DW'(in_item.row_index) < DW'(MAX_DIM)) &&
                    (DW'(in_item.col_index) < DW'(MAX_DIM));
  assign ld_addr  = cell_addr(IDX_W'(in_item.row_index), IDX_W'(in_item.col_index));

  assign a_addr = cell_addr(i_r, l_r);
  assign b_addr = cell_addr(l_r, j_r);
  assign c_addr = cell_addr(i_r, j_r);

  assign out_busy = out_valid_r && out_stall;
  assign emit_go  = ctrl.emit && !out_busy;
  assign is_last  = (DW'(i_r) == rows_m1) && (DW'(j_r) == cols_m1);

  assign stat.run_go       = in_acc && (in_item.mode == gmac_pkg::MODE_RUN) && !empty;
  assign stat.skip_inner   = (cfg.alpha == '0) || (inner_c == '0);
  assign stat.more_inner   = DW'(l_r) != inner_m1;
  assign stat.out_busy     = out_busy;
  assign stat.more_entries = !fin_r;

  // C write port: loads while idle, results during a run
  assign c_waddr = emit_go ? c_addr : ld_addr;
  assign c_wdata = emit_go ? acc_r : in_item.in_value;

  gmac_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (in_acc && ld_ok && (in_item.mode == gmac_pkg::MODE_LOAD_A)),
    .waddr (ld_addr),
    .wdata (in_item.in_value),
    .raddr (a_addr),
    .rdata (a_rd)
  );

  gmac_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (in_acc && ld_ok && (in_item.mode == gmac_pkg::MODE_LOAD_B)),
    .waddr (ld_addr),
    .wdata (in_item.in_value),
    .raddr (b_addr),
    .rdata (b_rd)
  );

  gmac_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_c_ram (
    .clk   (clk),
    .we    (emit_go || (in_acc && ld_ok && (in_item.mode == gmac_pkg::MODE_LOAD_C))),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_addr),
    .rdata (c_rd)
  );

  always_comb begin
    case (ctrl.mul)
      gmac_pkg::MUL_BETA_C: begin
        mul_x = cfg.beta;
        mul_y = c_rd;
      end
      gmac_pkg::MUL_ALPHA_B: begin
        mul_x = cfg.alpha;
        mul_y = b_rd;
      end
      gmac_pkg::MUL_P_A: begin
        mul_x = p_r;
        mul_y = a_rd;
      end
      default: begin
        mul_x = p_r;
        mul_y = a_rd;
      end
    endcase
    p_nxt = (ctrl.mul == gmac_pkg::MUL_NONE) ? p_r : mul_x * mul_y;
  end

  always_comb begin
    case (ctrl.acc)
      gmac_pkg::ACC_INIT: acc_nxt = (cfg.beta == '0) ? '0 : p_r;
      gmac_pkg::ACC_ADD:  acc_nxt = acc_r + p_r;
      default:            acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    case (ctrl.lop)
      gmac_pkg::L_CLEAR: l_nxt = '0;
      gmac_pkg::L_INC:   l_nxt = l_r + 1'b1;
      default:           l_nxt = l_r;
    endcase
  end

  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    fin_nxt = fin_r;
    if (stat.run_go) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (emit_go) begin
      fin_nxt = is_last;
      if (DW'(i_r) == rows_m1) begin
        i_nxt = '0;
        j_nxt = (DW'(j_r) == cols_m1) ? '0 : j_r + 1'b1;
      end else begin
        i_nxt = i_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_busy;
    if (emit_go) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.out_row     = 3'(i_r);
      out_item_nxt.out_col     = 3'(j_r);
      out_item_nxt.out_value   = acc_r;
      out_item_nxt.last_of_run = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      l_r         <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      l_r         <= l_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    acc_r      <= acc_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_inner_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.acc == gmac_pkg::ACC_ADD) |-> (DW'(l_r) < inner_c))
    else $error("inner index beyond summed dimension");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> (DW'(i_r) < rows_c) && (DW'(j_r) < cols_c))
    else $error("emitted entry outside C");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && is_last |=> (i_r == '0) && (j_r == '0) && fin_r)
    else $error("counters not wrapped after final entry");

endmodule

// File: hw/rtl/general_matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// general_matrix_multiply_accumulate
// C = alpha*A*B + beta*C on signed 32-bit words, wrapping modulo 2^32.
//
// Input channel (in_valid / in_stall / in_item): a load transaction writes
// one entry of A, B or C; loads stream at one per cycle while no run is in
// progress. A run transaction walks C in column-major order and sends every
// entry on the result channel (out_valid / out_stall / out_item), the final
// one with last_of_run set. in_stall stays high for the whole run.
// Run steps: for each C entry the microcode reads C, forms beta*C and
// initialises the accumulator; unless alpha or inner is zero it then loops
// over the inner index, reading A and B, forming alpha*B, multiplying by A
// and adding; last it emits the entry. All products share the single 32x32
// multiplier, and the RAM reads are registered.
// A stalled result holds in the output register; the sequencer waits at its
// emit step until the register frees.
// Config port (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; write only while no run is in progress.
// Reset: alpha 1, beta 0, all dimensions 8; the A/B/C stores are not
// cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module general_matrix_multiply_accumulate #(
  parameter int MAX_DIM = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  gmac_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output gmac_pkg::out_item_t                  out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gmac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gmac_pkg::ELEM_W-1:0]          cfg_data
);

  gmac_pkg::cfg_t  cfg_r, cfg_nxt;
  gmac_pkg::ctrl_t ctrl;
  gmac_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gmac_pkg::REG_ALPHA: cfg_nxt.alpha = cfg_data;
        gmac_pkg::REG_BETA:  cfg_nxt.beta  = cfg_data;
        gmac_pkg::REG_ROWS:  cfg_nxt.rows  = cfg_data[gmac_pkg::DIM_W-1:0];
        gmac_pkg::REG_COLS:  cfg_nxt.cols  = cfg_data[gmac_pkg::DIM_W-1:0];
        gmac_pkg::REG_INNER: cfg_nxt.inner = cfg_data[gmac_pkg::DIM_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha <= 32'sd1;
      cfg_r.beta  <= '0;
      cfg_r.rows  <= 4'd8;
      cfg_r.cols  <= 4'd8;
      cfg_r.inner <= 4'd8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gmac_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  gmac_dpath #(.MAX_DIM(MAX_DIM)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for general_matrix_multiply_accumulate. Loads A, B and
// C entries, runs C = alpha*A*B + beta*C under a series of register settings
// and compares every emitted C entry, in column-major order, against an
// in-bench model of the block. Both channels see random idle and stall gaps.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_DIM        = 8;
  localparam int CELLS          = MAX_DIM * MAX_DIM;
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 30;
  localparam int REPORT_LIMIT   = 10;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  gmac_pkg::in_item_t             in_item   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  gmac_pkg::out_item_t            out_item;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [gmac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gmac_pkg::ELEM_W-1:0]    cfg_data  = '0;

  general_matrix_multiply_accumulate #(.MAX_DIM(MAX_DIM)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // model state
  logic [31:0] a_words [CELLS];
  logic [31:0] b_words [CELLS];
  logic [31:0] c_words [CELLS];
  bit          a_loaded [CELLS];
  bit          b_loaded [CELLS];
  bit          c_loaded [CELLS];
  logic [31:0] alpha_w = 32'd1;
  logic [31:0] beta_w  = 32'd0;
  logic [3:0]  rows_w  = 4'd8;
  logic [3:0]  cols_w  = 4'd8;
  logic [3:0]  inner_w = 4'd8;

  gmac_pkg::out_item_t c_expected [$];
  int                  fail_count = 0;
  int                  items_sent = 0;
  bit                  in_hold    = 1'b0;
  bit                  no_idle    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] extreme_word(int k);
    case (k)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return extreme_word(r);
    return $urandom;
  endfunction

  function automatic logic [3:0] rand_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'($urandom_range(9, 15));
    if (r == 2) return 4'd8;
    return 4'($urandom_range(1, 4));
  endfunction

  function automatic int dim_of(logic [3:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  task automatic apply_reg(logic [gmac_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      gmac_pkg::REG_ALPHA: alpha_w = data;
      gmac_pkg::REG_BETA:  beta_w  = data;
      gmac_pkg::REG_ROWS:  rows_w  = data[3:0];
      gmac_pkg::REG_COLS:  cols_w  = data[3:0];
      gmac_pkg::REG_INNER: inner_w = data[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_item(gmac_pkg::in_item_t it);
    int                  k;
    int                  rn;
    int                  cn;
    int                  kn;
    int                  n;
    logic [31:0]         acc;
    logic [31:0]         scaled_b;
    gmac_pkg::out_item_t res;
    k = int'(it.row_index) * MAX_DIM + int'(it.col_index);
    case (it.mode)
      gmac_pkg::MODE_LOAD_A: begin
        a_words[k]  = it.in_value;
        a_loaded[k] = 1'b1;
      end
      gmac_pkg::MODE_LOAD_B: begin
        b_words[k]  = it.in_value;
        b_loaded[k] = 1'b1;
      end
      gmac_pkg::MODE_LOAD_C: begin
        c_words[k]  = it.in_value;
        c_loaded[k] = 1'b1;
      end
      default: begin
        rn = dim_of(rows_w);
        cn = dim_of(cols_w);
        kn = dim_of(inner_w);
        n  = 0;
        for (int j = 0; j < cn; j++) begin
          for (int i = 0; i < rn; i++) begin
            if (beta_w == '0) acc = '0;
            else acc = beta_w * c_words[i * MAX_DIM + j];
            if (alpha_w != '0) begin
              for (int l = 0; l < kn; l++) begin
                scaled_b = alpha_w * b_words[l * MAX_DIM + j];
                acc      = acc + scaled_b * a_words[i * MAX_DIM + l];
              end
            end
            c_words[i * MAX_DIM + j] = acc;
            n++;
            res.out_row     = 3'(i);
            res.out_col     = 3'(j);
            res.out_value   = acc;
            res.last_of_run = (n == rn * cn);
            c_expected.push_back(res);
          end
        end
      end
    endcase
    items_sent++;
  endtask

  task automatic send_item(gmac_pkg::in_item_t it);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    in_hold   = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_item(it);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_hold   = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic in_quiet();
    if (in_hold) begin
      in_valid <= 1'b0;
      in_hold   = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic load_entry(gmac_pkg::mode_t m, int r, int c, logic [31:0] v);
    gmac_pkg::in_item_t it;
    it.mode      = m;
    it.row_index = 3'(r);
    it.col_index = 3'(c);
    it.in_value  = v;
    send_item(it);
  endtask

  task automatic run_matrix();
    gmac_pkg::in_item_t it;
    it.mode      = gmac_pkg::MODE_RUN;
    it.row_index = 3'($urandom);
    it.col_index = 3'($urandom);
    it.in_value  = $urandom;
    send_item(it);
  endtask

  // load every operand entry the next run uses that has never been loaded
  task automatic cover_operands();
    int rn;
    int cn;
    int kn;
    rn = dim_of(rows_w);
    cn = dim_of(cols_w);
    kn = dim_of(inner_w);
    if (beta_w != '0)
      for (int j = 0; j < cn; j++)
        for (int i = 0; i < rn; i++)
          if (!c_loaded[i * MAX_DIM + j])
            load_entry(gmac_pkg::MODE_LOAD_C, i, j, rand_word());
    if (alpha_w != '0) begin
      for (int i = 0; i < rn; i++)
        for (int l = 0; l < kn; l++)
          if (!a_loaded[i * MAX_DIM + l])
            load_entry(gmac_pkg::MODE_LOAD_A, i, l, rand_word());
      for (int l = 0; l < kn; l++)
        for (int j = 0; j < cn; j++)
          if (!b_loaded[l * MAX_DIM + j])
            load_entry(gmac_pkg::MODE_LOAD_B, l, j, rand_word());
    end
  endtask

  task automatic write_reg(logic [gmac_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_dim(logic [gmac_pkg::CFG_IDX_W-1:0] idx, logic [3:0] d);
    logic [31:0] data;
    data      = $urandom;
    data[3:0] = d;
    write_reg(idx, data);
  endtask

  task automatic drain();
    in_quiet();
    while (c_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_values();
    write_dim(gmac_pkg::REG_COLS, 4'd1);
    write_dim(gmac_pkg::REG_INNER, 4'd1);
    cover_operands();
    run_matrix();
  endtask

  task automatic test_scalar_extremes();
    drain();
    write_dim(gmac_pkg::REG_ROWS, 4'd1);
    write_dim(gmac_pkg::REG_COLS, 4'd1);
    write_dim(gmac_pkg::REG_INNER, 4'd1);
    for (int k = 0; k < 5; k++) begin
      drain();
      write_reg(gmac_pkg::REG_ALPHA, extreme_word(k));
      write_reg(gmac_pkg::REG_BETA, extreme_word((k + 2) % 5));
      load_entry(gmac_pkg::MODE_LOAD_A, 0, 0, extreme_word((k + 1) % 5));
      load_entry(gmac_pkg::MODE_LOAD_B, 0, 0, extreme_word((k + 3) % 5));
      load_entry(gmac_pkg::MODE_LOAD_C, 0, 0, extreme_word((k + 4) % 5));
      run_matrix();
    end
  endtask

  task automatic test_inner_zero();
    drain();
    write_dim(gmac_pkg::REG_INNER, 4'd0);
    write_dim(gmac_pkg::REG_ROWS, 4'd3);
    write_dim(gmac_pkg::REG_COLS, 4'd2);
    write_reg(gmac_pkg::REG_ALPHA, 32'd7);
    write_reg(gmac_pkg::REG_BETA, 32'hffff_fffd);
    cover_operands();
    run_matrix();
    drain();
    write_reg(gmac_pkg::REG_BETA, 32'd1);
    run_matrix();
  endtask

  task automatic test_empty_matrix();
    drain();
    write_dim(gmac_pkg::REG_ROWS, 4'd0);
    write_dim(gmac_pkg::REG_COLS, 4'd3);
    run_matrix();
    drain();
    write_dim(gmac_pkg::REG_ROWS, 4'd2);
    write_dim(gmac_pkg::REG_COLS, 4'd0);
    run_matrix();
  endtask

  task automatic test_unknown_index();
    drain();
    write_dim(gmac_pkg::REG_ROWS, 4'd2);
    write_dim(gmac_pkg::REG_COLS, 4'd2);
    write_dim(gmac_pkg::REG_INNER, 4'd2);
    write_reg(gmac_pkg::REG_ALPHA, rand_word());
    write_reg(gmac_pkg::REG_BETA, rand_word());
    for (int k = gmac_pkg::REG_INNER + 1; k < (1 << gmac_pkg::CFG_IDX_W); k++)
      write_reg(gmac_pkg::CFG_IDX_W'(k), $urandom);
    cover_operands();
    run_matrix();
  endtask

  task automatic test_oversize_dims();
    drain();
    write_reg(gmac_pkg::REG_ALPHA, rand_word() | 32'd1);
    write_reg(gmac_pkg::REG_BETA, rand_word() | 32'd1);
    write_dim(gmac_pkg::REG_ROWS, 4'd15);
    write_dim(gmac_pkg::REG_COLS, 4'd1);
    write_dim(gmac_pkg::REG_INNER, 4'd0);
    cover_operands();
    run_matrix();
    drain();
    write_dim(gmac_pkg::REG_ROWS, 4'd1);
    write_dim(gmac_pkg::REG_COLS, 4'd9);
    cover_operands();
    run_matrix();
    drain();
    write_dim(gmac_pkg::REG_COLS, 4'd1);
    write_dim(gmac_pkg::REG_INNER, 4'd12);
    cover_operands();
    run_matrix();
  endtask

  task automatic test_back_to_back();
    drain();
    no_idle = 1'b1;
    write_dim(gmac_pkg::REG_ROWS, 4'd3);
    write_dim(gmac_pkg::REG_COLS, 4'd3);
    write_dim(gmac_pkg::REG_INNER, 4'd2);
    repeat (10)
      load_entry(gmac_pkg::mode_t'($urandom_range(gmac_pkg::MODE_LOAD_A,
                                                  gmac_pkg::MODE_LOAD_C)),
                 $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
    cover_operands();
    run_matrix();
    run_matrix();
    drain();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        if ($urandom_range(0, 1)) write_reg(gmac_pkg::REG_ALPHA, rand_word());
        if ($urandom_range(0, 1)) write_reg(gmac_pkg::REG_BETA, rand_word());
        if ($urandom_range(0, 1)) write_dim(gmac_pkg::REG_ROWS, rand_dim());
        if ($urandom_range(0, 1)) write_dim(gmac_pkg::REG_COLS, rand_dim());
        if ($urandom_range(0, 1)) write_dim(gmac_pkg::REG_INNER, rand_dim());
      end
      repeat ($urandom_range(0, 6))
        load_entry(gmac_pkg::mode_t'($urandom_range(gmac_pkg::MODE_LOAD_A,
                                                    gmac_pkg::MODE_LOAD_C)),
                   $urandom_range(0, 7), $urandom_range(0, 7), rand_word());
      if ($urandom_range(0, 4) != 0) begin
        cover_operands();
        run_matrix();
      end
    end
  endtask

  initial begin : stall_gen
    int n;
    @(posedge clk);
    forever begin
      n = no_idle ? 0 : pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (c_expected.size() == 0) begin
        if (fail_count < REPORT_LIMIT)
          $display("unexpected result: row %0d col %0d value %h last %0b",
                   out_item.out_row, out_item.out_col, out_item.out_value,
                   out_item.last_of_run);
        fail_count++;
      end else if (out_item.out_row     !== c_expected[0].out_row   ||
                   out_item.out_col     !== c_expected[0].out_col   ||
                   out_item.out_value   !== c_expected[0].out_value ||
                   out_item.last_of_run !== c_expected[0].last_of_run) begin
        if (fail_count < REPORT_LIMIT)
          $display("mismatch: expected row %0d col %0d value %h last %0b,",
                   c_expected[0].out_row, c_expected[0].out_col,
                   c_expected[0].out_value, c_expected[0].last_of_run,
                   " got row %0d col %0d value %h last %0b",
                   out_item.out_row, out_item.out_col, out_item.out_value,
                   out_item.last_of_run);
        fail_count++;
        void'(c_expected.pop_front());
      end else begin
        void'(c_expected.pop_front());
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_scalar_extremes();
    test_inner_zero();
    test_empty_matrix();
    test_unknown_index();
    test_oversize_dims();
    test_back_to_back();
    test_random_traffic();
    drain();
    if (fail_count == 0 && c_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/gmac_pkg.sv
hw/rtl/gmac_ram.sv
hw/rtl/gmac_useq.sv
hw/rtl/gmac_dpath.sv
hw/rtl/general_matrix_multiply_accumulate.sv
bench/testbench.sv
